FILE: hw/rtl/msort_pkg.sv
`default_nettype none

package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

endpackage

`default_nettype wire

FILE: hw/rtl/msort_ram.sv
`default_nettype none

module msort_ram
    import msort_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  we,
    input  wire addr_t waddr,
    input  wire word_t wdata,
    input  wire addr_t raddr0,
    input  wire addr_t raddr1,
    output word_t      rdata0,
    output word_t      rdata1
);

    word_t mem [CAPACITY];
    word_t rdata0_reg;
    word_t rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/merge_sorter.sv
// A set of n values is sorted in ceil(log2(n)) merge passes; each pass has one setup step per
// pair of runs, then reads and merges each value in turn, one shared comparator doing the work.
// Results leave one at a time (read, load, send); the next is read only once the last is taken.
// Input is taken one value per cycle while a set is collected; not ready while sorting or emitting.
// Reset (aresetn low, synchronous) clears the count, the overflow flag and the sequencer;
// the two ping-pong buffers are not cleared.
`default_nettype none

module merge_sorter
    import msort_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);

    typedef enum logic [6:0] {
        ST_COLLECT  = 7'b0000001,
        ST_SETUP    = 7'b0000010,
        ST_READ     = 7'b0000100,
        ST_MERGE    = 7'b0001000,
        ST_OUT_READ = 7'b0010000,
        ST_OUT_LOAD = 7'b0100000,
        ST_OUT_SEND = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic   src_sel_reg, src_sel_next;
    cnt_t   width_reg, width_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    cnt_t   k_reg, k_next;
    word_t  m_tdata_reg, m_tdata_next;
    logic   m_tlast_reg, m_tlast_next;
    logic   m_tuser_reg, m_tuser_next;
    logic   m_tvalid_reg, m_tvalid_next;

    word_t  a_rd0, a_rd1, b_rd0, b_rd1;
    word_t  rd_i, rd_j, merge_word;
    logic   take_left, in_accept, has_room;
    cnt_t   mid_calc, hi_calc, width_dbl;
    addr_t  raddr0, raddr1;
    logic   a_we, b_we;
    addr_t  a_waddr;
    word_t  a_wdata;

    assign in_accept = s_tvalid && s_tready;
    assign has_room  = count_reg < CAP_CNT;
    assign s_tready  = (state_reg == ST_COLLECT);

    assign rd_i = src_sel_reg ? b_rd0 : a_rd0;
    assign rd_j = src_sel_reg ? b_rd1 : a_rd1;

    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(rd_i) <= $signed(rd_j)));
    assign merge_word = take_left ? rd_i : rd_j;

    assign width_dbl = cnt_t'(width_reg << 1);

    always_comb begin
        mid_calc = lo_reg + width_reg;
        hi_calc  = lo_reg + width_dbl;
        if (mid_calc > count_reg) begin
            mid_calc = count_reg;
        end
        if (hi_calc > count_reg) begin
            hi_calc = count_reg;
        end
    end

    assign raddr0 = (state_reg == ST_OUT_READ) ? k_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign raddr1 = j_reg[ADDR_W-1:0];

    assign a_we    = (in_accept && has_room) || ((state_reg == ST_MERGE) && src_sel_reg);
    assign a_waddr = (state_reg == ST_COLLECT) ? count_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign a_wdata = (state_reg == ST_COLLECT) ? s_tdata : merge_word;
    assign b_we    = (state_reg == ST_MERGE) && !src_sel_reg;

    msort_ram u_buf_a (
        .aclk   (aclk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    msort_ram u_buf_b (
        .aclk   (aclk),
        .we     (b_we),
        .waddr  (k_reg[ADDR_W-1:0]),
        .wdata  (merge_word),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        src_sel_next  = src_sel_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;

        unique case (state_reg)
            ST_COLLECT: begin
                if (in_accept) begin
                    if (has_room) begin
                        count_next = count_reg + cnt_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        src_sel_next = 1'b0;
                        width_next   = cnt_t'(1);
                        lo_next      = '0;
                        k_next       = '0;
                        if (count_next <= cnt_t'(1)) begin
                            state_next = ST_OUT_READ;
                        end else begin
                            state_next = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP: begin
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                i_next     = lo_reg;
                j_next     = mid_calc;
                k_next     = lo_reg;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (take_left) begin
                    i_next = i_reg + cnt_t'(1);
                end else begin
                    j_next = j_reg + cnt_t'(1);
                end
                k_next = k_reg + cnt_t'(1);
                if (k_next == hi_reg) begin
                    if (hi_reg == count_reg) begin
                        src_sel_next = !src_sel_reg;
                        width_next   = width_dbl;
                        lo_next      = '0;
                        if (width_dbl >= count_reg) begin
                            k_next     = '0;
                            state_next = ST_OUT_READ;
                        end else begin
                            state_next = ST_SETUP;
                        end
                    end else begin
                        lo_next    = hi_reg;
                        state_next = ST_SETUP;
                    end
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_OUT_READ: begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                m_tdata_next  = rd_i;
                m_tlast_next  = (k_reg + cnt_t'(1)) == count_reg;
                m_tuser_next  = ovf_reg;
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        src_sel_next = 1'b0;
                        state_next   = ST_COLLECT;
                    end else begin
                        k_next     = k_reg + cnt_t'(1);
                        state_next = ST_OUT_READ;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            src_sel_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            src_sel_reg  <= src_sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        width_reg   <= width_next;
        lo_reg      <= lo_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
